FILE: hw/rtl/sacl_pkg.sv
// Shared types and constants for the set-associative cache lookup block.
`default_nettype none

package sacl_pkg;

    // Geometry defaults and fixed widths
    localparam int CACHE_BYTES_DEF = 16384;
    localparam int ADDR_BITS_DEF   = 26;
    localparam int ENTRY_BYTES     = 16;    // one tag entry per 16 bytes of capacity
    localparam int MAX_WAYS        = 16;    // one memory row holds this many ways
    localparam int LANE_W          = 4;     // log2(MAX_WAYS)
    localparam int TAG_W           = 16;
    localparam int SET_W           = 15;    // index_bits may be written up to 15
    localparam int ENTRY_FULL_W    = SET_W + LANE_W;
    localparam int SHIFT_W         = 5;     // offset_bits + index_bits reaches 22

    // Register field widths and reset values
    localparam int OFFSET_W = 3;
    localparam int INDEX_W  = 4;
    localparam int WAYS_W   = 3;
    localparam logic [OFFSET_W-1:0] OFFSET_RST = 3'd4;
    localparam logic [INDEX_W-1:0]  INDEX_RST  = 4'd10;
    localparam logic [WAYS_W-1:0]   WAYS_RST   = 3'd0;
    localparam logic [WAYS_W-1:0]   WAYS_LOG2_MAX = 3'd4;

    // Register indexes (paddr[3:2])
    localparam logic [1:0] REG_OFFSET = 2'd0;
    localparam logic [1:0] REG_INDEX  = 2'd1;
    localparam logic [1:0] REG_WAYS   = 2'd2;

    // Multiply-with-carry generator
    localparam logic [15:0] RNG_Z_MUL = 16'd36969;
    localparam logic [15:0] RNG_W_MUL = 16'd18000;
    localparam logic [31:0] RNG_Z_RST = 32'h0508_0902;
    localparam logic [31:0] RNG_W_RST = 32'hABAB_AB55;

    typedef struct packed {
        logic [OFFSET_W-1:0] offset_bits;
        logic [INDEX_W-1:0]  index_bits;
        logic [WAYS_W-1:0]   ways_log2;
    } t_cfg;

    // Controller to datapath
    typedef struct packed {
        logic load;     // capture input word
        logic rd_en;    // read set row
        logic commit;   // compare, fill on miss, load result
        logic clr_en;   // clearing pass write
    } t_cmd;

    // Datapath to controller
    typedef struct packed {
        logic clr_last;
    } t_stat;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_CMP
    } t_state;

    // One memory row: valid bits and tags of MAX_WAYS entries
    typedef struct packed {
        logic [MAX_WAYS-1:0]            vld;
        logic [MAX_WAYS-1:0][TAG_W-1:0] tag;
    } t_row;

endpackage

`default_nettype wire

FILE: hw/rtl/sacl_ctrl.sv
// Controller state machine for the cache lookup: clear pass, read, compare.
`default_nettype none

module sacl_ctrl
    import sacl_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_s_tvalid,
    output logic       o_s_tready,
    output logic       o_m_tvalid,
    input  wire logic  i_m_tready,
    output t_cmd       o_cmd,
    input  wire t_stat i_stat
);

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   go;

    // Result slot is free or drains this cycle
    assign go = !r_out_valid || i_m_tready;

    // State register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    // Next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_CLEAR: begin
                if (i_stat.clr_last) n_state = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_s_tvalid) n_state = ST_READ;
            end
            ST_READ: begin
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (go) n_state = i_s_tvalid ? ST_READ : ST_IDLE;
            end
            default: begin
                n_state = ST_CLEAR;
            end
        endcase
    end

    // Outputs and commands
    always_comb begin
        o_s_tready   = 1'b0;
        o_cmd        = '0;
        case (r_state)
            ST_CLEAR: begin
                o_cmd.clr_en = 1'b1;
            end
            ST_IDLE: begin
                o_s_tready = 1'b1;
            end
            ST_READ: begin
                o_cmd.rd_en = 1'b1;
            end
            ST_CMP: begin
                o_s_tready   = go;
                o_cmd.commit = go;
            end
            default: begin
                o_s_tready = 1'b0;
            end
        endcase
        o_cmd.load = i_s_tvalid && o_s_tready;
    end

    // Result valid flag
    always_comb begin
        if (o_cmd.commit) n_out_valid = 1'b1;
        else if (i_m_tready) n_out_valid = 1'b0;
        else n_out_valid = r_out_valid;
    end

    assign o_m_tvalid = r_out_valid;

    // A pending result word is never overwritten
    ap_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_m_tready) |-> !o_cmd.commit)
        else $error("result overwritten while stalled");

    // An accepted word always goes to the row read next
    ap_load_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.load |=> (r_state == ST_READ))
        else $error("accepted word not followed by a read");

    // A row read is always followed by the compare stage
    ap_read_cmp: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_READ) |=> (r_state == ST_CMP))
        else $error("read not followed by compare");

    // Result valid only rises after a commit
    ap_valid_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> $past(o_cmd.commit))
        else $error("result valid without commit");

endmodule

`default_nettype wire

FILE: hw/rtl/sacl_datapath.sv
// Datapath: address split, tag row memory, way compare, fill and generator.
`default_nettype none

module sacl_datapath
    import sacl_pkg::*;
#(
    parameter int CACHE_BYTES = CACHE_BYTES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire t_cfg                 i_cfg,
    input  wire t_cmd                 i_cmd,
    output t_stat                     o_stat,
    input  wire logic [ADDR_BITS-1:0] i_addr,
    output logic                      o_hit
);

    localparam int ENTRIES = CACHE_BYTES / ENTRY_BYTES;
    localparam int EW      = $clog2(ENTRIES);
    localparam int ROWS    = ENTRIES / MAX_WAYS;
    localparam int RW      = $clog2(ROWS);

    // Tag row memory
    t_row mem [ROWS];

    logic [ADDR_BITS-1:0] r_addr;
    logic [RW-1:0]        r_row;
    logic [LANE_W-1:0]    r_base;
    logic [LANE_W-1:0]    r_wmask;
    logic [TAG_W-1:0]     r_tag;
    t_row                 r_rd;
    logic [RW-1:0]        r_clr_row;
    logic [31:0]          r_z, r_w;
    logic                 r_hit;

    // Address split from the captured word
    logic [WAYS_W-1:0]       wl;
    logic [SET_W-1:0]        set_mask;
    logic [SET_W-1:0]        set_idx;
    logic [SHIFT_W-1:0]      tag_sh;
    logic [TAG_W-1:0]        tag;
    logic [ENTRY_FULL_W-1:0] entry_full;
    logic [EW-1:0]           entry0;
    logic [RW-1:0]           row;
    logic [LANE_W-1:0]       wmask;

    always_comb begin
        wl         = (i_cfg.ways_log2 > WAYS_LOG2_MAX) ? WAYS_LOG2_MAX : i_cfg.ways_log2;
        set_mask   = SET_W'((16'd1 << i_cfg.index_bits) - 16'd1);
        set_idx    = SET_W'(r_addr >> i_cfg.offset_bits) & set_mask;
        tag_sh     = SHIFT_W'(i_cfg.offset_bits) + SHIFT_W'(i_cfg.index_bits);
        tag        = TAG_W'(r_addr >> tag_sh);
        entry_full = ENTRY_FULL_W'(set_idx) << wl;
        entry0     = entry_full[EW-1:0];
        row        = entry0[EW-1:LANE_W];
        wmask      = LANE_W'((5'd1 << wl) - 5'd1);
    end

    // Input capture and lookup parameters for the compare stage
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) r_addr <= i_addr;
        if (i_cmd.rd_en) begin
            r_row   <= row;
            r_base  <= entry0[LANE_W-1:0];
            r_wmask <= wmask;
            r_tag   <= tag;
        end
    end

    // Generator step (taken only when a miss finds the set full)
    logic [31:0] n_z, n_w;
    always_comb begin
        n_z = ({16'd0, r_z[15:0]} * {16'd0, RNG_Z_MUL}) + {16'd0, r_z[31:16]};
        n_w = ({16'd0, r_w[15:0]} * {16'd0, RNG_W_MUL}) + {16'd0, r_w[31:16]};
    end

    // Way compare and fill selection
    logic [MAX_WAYS-1:0] in_set, hit_v, free_v;
    logic                hit, full;
    logic [LANE_W-1:0]   first_free, victim, fill_lane;
    t_row                wr_row;

    always_comb begin
        for (int l = 0; l < MAX_WAYS; l++) begin
            in_set[l] = ((LANE_W'(l) & ~r_wmask) == r_base);
            hit_v[l]  = in_set[l] && r_rd.vld[l] && (r_rd.tag[l] == r_tag);
            free_v[l] = in_set[l] && !r_rd.vld[l];
        end
        hit  = |hit_v;
        full = ~|free_v;
        first_free = '0;
        for (int l = MAX_WAYS - 1; l >= 0; l--) begin
            if (free_v[l]) first_free = LANE_W'(l);
        end
        // low bits of (z << 16) + w come from w alone
        victim    = r_base | (n_w[LANE_W-1:0] & r_wmask);
        fill_lane = full ? victim : first_free;
        wr_row    = r_rd;
        wr_row.vld[fill_lane] = 1'b1;
        wr_row.tag[fill_lane] = r_tag;
    end

    // Memory write port (clear pass or fill) and registered row read
    logic          wr_en;
    logic [RW-1:0] wr_addr;
    t_row          wr_data;

    always_comb begin
        wr_en   = i_cmd.clr_en || (i_cmd.commit && !hit);
        wr_addr = i_cmd.clr_en ? r_clr_row : r_row;
        wr_data = i_cmd.clr_en ? t_row'('0) : wr_row;
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) mem[wr_addr] <= wr_data;
        if (i_cmd.rd_en) r_rd <= mem[row];
    end

    // Clearing pass counter and generator state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_row <= '0;
            r_z       <= RNG_Z_RST;
            r_w       <= RNG_W_RST;
        end else begin
            if (i_cmd.clr_en) r_clr_row <= r_clr_row + RW'(1);
            if (i_cmd.commit && !hit && full) begin
                r_z <= n_z;
                r_w <= n_w;
            end
        end
    end

    assign o_stat.clr_last = (r_clr_row == RW'(ROWS - 1));

    // Result word
    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) r_hit <= hit;
    end

    assign o_hit = r_hit;

endmodule

`default_nettype wire

FILE: hw/rtl/set_assoc_cache_lookup.sv
// An accepted word is captured and its tag row is read into a register; the compare
// and write-back step then registers its hit/miss result word, holding while the
// last result is unread. A new word is taken only when idle or during that compare.
// Reset: synchronous, active low; registers return to offset 4, index 10, 1 way.
// After reset a clearing pass writes each of the ENTRIES/16 tag rows invalid
// (64 at the default size), during which s_tready stays low.
`default_nettype none

module set_assoc_cache_lookup
    import sacl_pkg::*;
#(
    parameter int CACHE_BYTES = CACHE_BYTES_DEF,
    parameter int ADDR_BITS   = ADDR_BITS_DEF
) (
    input  wire logic                i_clk,
    input  wire logic                i_rst_n,
    // Configuration port
    input  wire logic                psel,
    input  wire logic                penable,
    input  wire logic                pwrite,
    input  wire logic [3:0]          paddr,
    input  wire logic [31:0]         pwdata,
    output logic      [31:0]         prdata,
    output logic                     pready,
    // Input stream
    input  wire logic                s_tvalid,
    output logic                     s_tready,
    input  wire logic [((ADDR_BITS+7)/8)*8-1:0] s_tdata,  // [ADDR_BITS-1:0] address
    // Result stream
    output logic                     m_tvalid,
    input  wire logic                m_tready,
    output logic      [7:0]          m_tdata              // [0] hit
);

    t_cfg  r_cfg;
    t_cmd  cmd;
    t_stat stat;
    logic  cfg_wr;
    logic  hit;

    // Configuration registers
    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.offset_bits <= OFFSET_RST;
            r_cfg.index_bits  <= INDEX_RST;
            r_cfg.ways_log2   <= WAYS_RST;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_OFFSET: r_cfg.offset_bits <= pwdata[OFFSET_W-1:0];
                REG_INDEX:  r_cfg.index_bits  <= pwdata[INDEX_W-1:0];
                REG_WAYS:   r_cfg.ways_log2   <= pwdata[WAYS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // Register readback
    always_comb begin
        case (paddr[3:2])
            REG_OFFSET: prdata = {{(32-OFFSET_W){1'b0}}, r_cfg.offset_bits};
            REG_INDEX:  prdata = {{(32-INDEX_W){1'b0}}, r_cfg.index_bits};
            REG_WAYS:   prdata = {{(32-WAYS_W){1'b0}}, r_cfg.ways_log2};
            default:    prdata = '0;
        endcase
    end

    sacl_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .o_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .o_cmd      (cmd),
        .i_stat     (stat)
    );

    sacl_datapath #(
        .CACHE_BYTES (CACHE_BYTES),
        .ADDR_BITS   (ADDR_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_cmd   (cmd),
        .o_stat  (stat),
        .i_addr  (s_tdata[ADDR_BITS-1:0]),
        .o_hit   (hit)
    );

    assign m_tdata = {7'd0, hit};

endmodule

`default_nettype wire
